FILE: sv/spg_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// spg_pkg
// Shared constants of the Sobol point generator: field widths, command codes,
// register map and default sizes.
// -----------------------------------------------------------------------------
package spg_pkg;

	localparam int DEF_MAX_DIMS   = 16;
	localparam int DEF_WORD_BITS  = 32;
	localparam int DEF_MAX_DEGREE = 18;

	localparam int CMD_W   = 3;
	localparam int DIMF_W  = 4;
	localparam int DEG_W   = 5;
	localparam int COEFF_W = 17;
	localparam int WIDX_W  = 5;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 32;
	localparam int CFG_W   = 5;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CFG_W-1:0] DIMS_RESET = 5'd1;

	// byte address of the dims_in_use register
	localparam logic [APB_AW-1:0] ADDR_DIMS_IN_USE = 3'd0;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SHIFT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POINT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

endpackage

`default_nettype wire

FILE: sv/spg_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// spg_if
// Valid/ready channels of the Sobol point generator: command items in,
// coordinates out.
// -----------------------------------------------------------------------------
interface spg_in_if import spg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [DIMF_W-1:0]  dim;
	logic [DEG_W-1:0]   degree;
	logic [COEFF_W-1:0] coeff;
	logic [WIDX_W-1:0]  word_index;
	logic [VAL_W-1:0]   value;
	logic [IDX_W-1:0]   point_index;

	modport source (output valid, cmd, dim, degree, coeff, word_index, value, point_index,
		input ready);
	modport sink (input valid, cmd, dim, degree, coeff, word_index, value, point_index,
		output ready);
endinterface

interface spg_out_if import spg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIMF_W-1:0] out_dim;
	logic [VAL_W-1:0]  coordinate;
	logic              last;
	logic [IDX_W-1:0]  seq_index;

	modport source (output valid, out_dim, coordinate, last, seq_index, input ready);
	modport sink (input valid, out_dim, coordinate, last, seq_index, output ready);
endinterface

`default_nettype wire

FILE: sv/spg_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// spg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module spg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/spg_cfg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// spg_cfg
// APB register slice holding dims_in_use.
// -----------------------------------------------------------------------------
module spg_cfg import spg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [CFG_W-1:0]  dims_in_use
);

	logic [CFG_W-1:0] dims_q;
	logic             hit;

	assign pready = 1'b1;
	// word aligned decode, byte lanes ignored
	assign hit = (paddr[APB_AW-1:2] == ADDR_DIMS_IN_USE[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			dims_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata      = hit ? {{(APB_DW-CFG_W){1'b0}}, dims_q} : '0;
	assign dims_in_use = dims_q;

endmodule

`default_nettype wire

FILE: sv/spg_engine.sv
`default_nettype none
// -----------------------------------------------------------------------------
// spg_engine
// Command sequencer: loads and expands direction words in the direction RAM,
// accumulates Gray-code points, walks the sequential point and drives the
// coordinate output register.
// -----------------------------------------------------------------------------
module spg_engine import spg_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
	localparam int KW = $clog2(WORD_BITS),
	localparam int AW = DW + KW
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	spg_in_if.sink                    items,
	spg_out_if.source                 coords,
	input  wire logic [CFG_W-1:0]     dims_in_use,
	output logic                      ram_we,
	output logic      [AW-1:0]        ram_waddr,
	output logic      [WORD_BITS-1:0] ram_wdata,
	output logic      [AW-1:0]        ram_raddr,
	input  wire logic [WORD_BITS-1:0] ram_rdata
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_EX_RD  = 9'b000000010,
		ST_EX_ACC = 9'b000000100,
		ST_EX_WR  = 9'b000001000,
		ST_RA_RD  = 9'b000010000,
		ST_RA_ACC = 9'b000100000,
		ST_EMIT   = 9'b001000000,
		ST_SQ_RD  = 9'b010000000,
		ST_SQ_ACC = 9'b100000000
	} state_t;

	localparam int WB = WORD_BITS;

	state_t               state_q;
	logic                 seq_mode_q;
	logic [DW-1:0]        dim_q;
	logic [DEG_W-1:0]     deg_q;
	logic [COEFF_W-1:0]   coeff_q;
	logic [WB-1:0]        gray_q;
	logic [IDX_W-1:0]     idx_q;
	logic [DW-1:0]        d_q;
	logic [KW-1:0]        k_q;
	logic [DEG_W-1:0]     l_q;
	logic [WB-1:0]        acc_q;
	logic [IDX_W-1:0]     seq_q;
	logic [KW-1:0]        c_q;
	logic [WB-1:0]        runpt_q [MAX_DIMS];
	logic [WB-1:0]        shift_q [MAX_DIMS];
	logic                 rd_dim0_s1;
	logic [KW-1:0]        rd_k_s1;

	logic                 out_valid_q;
	logic [DIMF_W-1:0]    out_dim_q;
	logic [VAL_W-1:0]     out_coord_q;
	logic                 out_last_q;
	logic [IDX_W-1:0]     out_idx_q;

	logic                 accept;
	logic                 slot_free;
	logic [WB-1:0]        word;
	logic [7:0]           nd;
	logic                 is_last;
	logic                 load_ok;
	logic                 load_expand;
	logic [5:0]           m_sh;
	logic [DEG_W-1:0]     bidx;
	logic [COEFF_W-1:0]   coeff_sh;
	logic [WB-1:0]        emit_val;

	function automatic logic [KW-1:0] ones_pos(input logic [IDX_W-1:0] n);
		logic [5:0] c;
		c = 6'd32;
		for (int i = IDX_W - 1; i >= 0; i--) begin
			if (!n[i]) begin
				c = 6'(i);
			end
		end
		if (c > 6'(WB - 1)) begin
			c = 6'(WB - 1);
		end
		return KW'(c);
	endfunction

	assign accept    = items.valid && items.ready;
	assign slot_free = !out_valid_q || coords.ready;
	assign items.ready = (state_q == ST_IDLE);

	// dimension 0 words are fixed and never stored
	assign word = rd_dim0_s1 ? ({{(WB-1){1'b0}}, 1'b1} << (KW'(WB - 1) - rd_k_s1)) : ram_rdata;

	always_comb begin
		nd = {3'd0, dims_in_use};
		if (dims_in_use == '0) begin
			nd = 8'd1;
		end else if (nd > 8'(MAX_DIMS)) begin
			nd = 8'(MAX_DIMS);
		end
	end
	assign is_last = ((8'(d_q) + 8'd1) == nd);

	assign load_ok = (items.dim != '0) && (8'(items.dim) < 8'(MAX_DIMS))
		&& (items.degree != '0) && (8'(items.degree) <= 8'(MAX_DEGREE))
		&& (items.word_index < items.degree) && (8'(items.word_index) < 8'(WB));
	assign load_expand = ((8'(items.word_index) + 8'd1) == 8'(items.degree))
		&& (8'(items.degree) < 8'(WB));
	assign m_sh = 6'(WB - 1) - 6'(items.word_index);

	assign bidx     = deg_q - DEG_W'(1) - l_q;
	assign coeff_sh = coeff_q >> bidx;
	assign emit_val = (seq_mode_q ? runpt_q[d_q] : acc_q) ^ shift_q[d_q];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {dim_q, k_q};
		ram_wdata = acc_q;
		if (state_q == ST_IDLE && accept && items.cmd == CMD_LOAD && load_ok) begin
			ram_we    = 1'b1;
			ram_waddr = {DW'(items.dim), KW'(items.word_index)};
			ram_wdata = WB'(items.value << m_sh);
		end else if (state_q == ST_EX_WR) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		case (state_q)
			ST_EX_RD: ram_raddr = {dim_q, KW'(k_q - KW'(l_q))};
			ST_SQ_RD: ram_raddr = {d_q, c_q};
			default:  ram_raddr = {d_q, k_q};
		endcase
	end

	always_ff @(posedge clk) begin
		rd_dim0_s1 <= (ram_raddr[AW-1:KW] == '0);
		rd_k_s1    <= ram_raddr[KW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seq_mode_q  <= 1'b0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				runpt_q[i] <= '0;
				shift_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && coords.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (items.cmd)
							CMD_LOAD: begin
								dim_q   <= DW'(items.dim);
								deg_q   <= items.degree;
								coeff_q <= items.coeff;
								k_q     <= KW'(items.degree);
								l_q     <= items.degree;
								acc_q   <= '0;
								if (load_ok && load_expand) begin
									state_q <= ST_EX_RD;
								end
							end
							CMD_SHIFT: begin
								if (8'(items.dim) < 8'(MAX_DIMS)) begin
									shift_q[DW'(items.dim)] <= WB'(items.value);
								end
							end
							CMD_POINT: begin
								seq_mode_q <= 1'b0;
								idx_q      <= items.point_index;
								gray_q     <= WB'(items.point_index ^ (items.point_index >> 1));
								d_q        <= '0;
								k_q        <= '0;
								acc_q      <= '0;
								state_q    <= ST_RA_RD;
							end
							CMD_NEXT: begin
								seq_mode_q <= 1'b1;
								idx_q      <= seq_q;
								c_q        <= ones_pos(seq_q);
								d_q        <= '0;
								state_q    <= ST_EMIT;
							end
							CMD_RESTART: begin
								seq_q <= '0;
								for (int i = 0; i < MAX_DIMS; i++) begin
									runpt_q[i] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_EX_RD: state_q <= ST_EX_ACC;
				ST_EX_ACC: begin
					// oldest tap carries the self-shift term
					if (l_q == deg_q) begin
						acc_q <= acc_q ^ word ^ (word >> deg_q);
					end else if (coeff_sh[0]) begin
						acc_q <= acc_q ^ word;
					end
					if (l_q == DEG_W'(1)) begin
						state_q <= ST_EX_WR;
					end else begin
						l_q     <= l_q - DEG_W'(1);
						state_q <= ST_EX_RD;
					end
				end
				ST_EX_WR: begin
					if (k_q == KW'(WB - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + KW'(1);
						l_q     <= deg_q;
						acc_q   <= '0;
						state_q <= ST_EX_RD;
					end
				end
				ST_RA_RD: state_q <= ST_RA_ACC;
				ST_RA_ACC: begin
					if (gray_q[k_q]) begin
						acc_q <= acc_q ^ word;
					end
					if (k_q == KW'(WB - 1)) begin
						state_q <= ST_EMIT;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= ST_RA_RD;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_dim_q   <= DIMF_W'(d_q);
						out_coord_q <= VAL_W'(emit_val);
						out_last_q  <= is_last;
						out_idx_q   <= idx_q;
						if (is_last) begin
							d_q     <= '0;
							state_q <= seq_mode_q ? ST_SQ_RD : ST_IDLE;
						end else begin
							d_q     <= d_q + DW'(1);
							k_q     <= '0;
							acc_q   <= '0;
							state_q <= seq_mode_q ? ST_EMIT : ST_RA_RD;
						end
					end
				end
				ST_SQ_RD: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					// advance every dimension, in use or not
					runpt_q[d_q] <= runpt_q[d_q] ^ word;
					if (d_q == DW'(MAX_DIMS - 1)) begin
						seq_q   <= seq_q + IDX_W'(1);
						state_q <= ST_IDLE;
					end else begin
						d_q     <= d_q + DW'(1);
						state_q <= ST_SQ_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign coords.valid      = out_valid_q;
	assign coords.out_dim    = out_dim_q;
	assign coords.coordinate = out_coord_q;
	assign coords.last       = out_last_q;
	assign coords.seq_index  = out_idx_q;

endmodule

`default_nettype wire

FILE: sv/sobol_point_generator.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sobol_point_generator
// Sobol point generator with Gray-code random access, sequential walk and a
// digital shift per dimension.
// -----------------------------------------------------------------------------
// All direction words sit in one RAM with a single read port and a registered
// read; every cost below comes from that port. A point-at-index item takes,
// per dimension in use, one read and one accumulate per direction word, then
// the output transfer. A next item takes one output transfer per dimension in
// use, then one read and one accumulate to advance the running point of every
// dimension. The load of a dimension's final initial word expands the
// remaining words, each from s reads and accumulates and a write for degree s.
// Other items are handled in the idle state. Coordinates leave through an output register,
// so a stalled consumer only holds the block once the next coordinate is due.
// -----------------------------------------------------------------------------
module sobol_point_generator import spg_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	spg_in_if.sink                 items,
	spg_out_if.source              coords,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int KW = $clog2(WORD_BITS);
	localparam int AW = DW + KW;

	logic [CFG_W-1:0]     dims_in_use;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	spg_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.dims_in_use (dims_in_use)
	);

	spg_engine #(
		.MAX_DIMS   (MAX_DIMS),
		.WORD_BITS  (WORD_BITS),
		.MAX_DEGREE (MAX_DEGREE)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.coords      (coords),
		.dims_in_use (dims_in_use),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	spg_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (2 ** AW)
	) u_dir_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// dimension 0 words are fixed and must never be overwritten
	a_no_dim0_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr[AW-1:KW] != '0)
		else $error("direction RAM write to dimension 0");

	// while idle, only an accepted load may write the direction RAM
	a_idle_write_is_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && items.ready) |-> (items.valid && items.cmd == CMD_LOAD))
		else $error("direction RAM write while idle without a load transfer");

endmodule

`default_nettype wire
